@@ rtl/ptom_pkg.sv @@
package ptom_pkg;

	localparam int BOOK_DEPTH  = 32;
	localparam int CNT_W       = $clog2(BOOK_DEPTH + 1);
	localparam int PRICE_W     = 31;
	localparam int QTY_W       = 31;
	localparam int ID_W        = 32;
	localparam int STAMP_W     = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		KIND_TRADE    = 3'd0,
		KIND_SETTLED  = 3'd1,
		KIND_REJECTED = 3'd2,
		KIND_DROPPED  = 3'd3
	} kind_t;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
		logic [ID_W-1:0]    id;
		logic [STAMP_W-1:0] arrival;
	} book_entry_t;

	typedef struct packed {
		logic        invalid;
		logic        side;
		book_entry_t entry;
	} queue_item_t;

	typedef struct packed {
		logic             ins;
		logic             pop;
		logic             set_qty;
		logic [QTY_W-1:0] new_qty;
	} side_ctrl_t;

endpackage

@@ rtl/ptom_order_if.sv @@
interface ptom_order_if;
	logic        valid;
	logic        ready;
	logic        side;
	logic [31:0] order_id;
	logic signed [31:0] price;
	logic signed [31:0] quantity;
	logic [31:0] arrival_time;

	modport source (output valid, side, order_id, price, quantity, arrival_time, input ready);
	modport sink (input valid, side, order_id, price, quantity, arrival_time, output ready);
endinterface

@@ rtl/ptom_result_if.sv @@
interface ptom_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] buy_order_id;
	logic [31:0] sell_order_id;
	logic [30:0] trade_price;
	logic [30:0] trade_quantity;
	logic        last;

	modport source (output valid, kind, buy_order_id, sell_order_id, trade_price,
		trade_quantity, last, input ready);
	modport sink (input valid, kind, buy_order_id, sell_order_id, trade_price,
		trade_quantity, last, output ready);
endinterface

@@ rtl/ptom_front.sv @@
module ptom_front import ptom_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ptom_order_if.sink   order,
	output logic         push,
	output queue_item_t  push_item,
	input  logic         full
);

	logic        valid_s1;
	queue_item_t item_s1;
	logic        bad;

	// positive means sign clear and nonzero
	assign bad = order.price[31] || (order.price == 32'sd0) ||
		order.quantity[31] || (order.quantity == 32'sd0);

	assign push        = valid_s1 && !full;
	assign push_item   = item_s1;
	assign order.ready = !valid_s1 || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (order.ready) begin
			valid_s1 <= order.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (order.valid && order.ready) begin
			item_s1.invalid       <= bad;
			item_s1.side          <= order.side;
			item_s1.entry.price   <= order.price[PRICE_W-1:0];
			item_s1.entry.qty     <= order.quantity[QTY_W-1:0];
			item_s1.entry.id      <= order.order_id;
			item_s1.entry.arrival <= order.arrival_time;
		end
	end

endmodule

@@ rtl/ptom_fifo.sv @@
module ptom_fifo import ptom_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  queue_item_t push_item,
	output logic        full,
	input  logic        pop,
	output queue_item_t item,
	output logic        valid
);

	queue_item_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QPTR_W:0]    fill_q;

	assign full  = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign valid = (fill_q != '0);
	assign item  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) fill_q <= fill_q + 1'b1;
			else if (pop && !push) fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule

@@ rtl/ptom_side.sv @@
module ptom_side import ptom_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             is_bid,
	input  side_ctrl_t       ctrl,
	input  book_entry_t      ins_entry,
	output book_entry_t      head,
	output logic [CNT_W-1:0] count
);

	book_entry_t            entries_q [BOOK_DEPTH];
	book_entry_t            entries_d [BOOK_DEPTH];
	logic [BOOK_DEPTH-1:0]  ge;
	logic [CNT_W-1:0]       count_q;

	function automatic logic new_better(input logic bid, input book_entry_t a,
		input book_entry_t b);
		logic r;
		if (a.price == b.price) r = a.arrival < b.arrival;
		else if (bid) r = a.price > b.price;
		else r = a.price < b.price;
		return r;
	endfunction

	assign head  = entries_q[0];
	assign count = count_q;

	// entries kept sorted by priority; ge marks the prefix the new order goes after
	always_comb begin
		for (int i = 0; i < BOOK_DEPTH; i++) begin
			ge[i] = (CNT_W'(i) < count_q) && !new_better(is_bid, ins_entry, entries_q[i]);
		end
		for (int i = 0; i < BOOK_DEPTH; i++) entries_d[i] = entries_q[i];
		if (ctrl.ins) begin
			if (!ge[0]) entries_d[0] = ins_entry;
			for (int i = 1; i < BOOK_DEPTH; i++) begin
				if (!ge[i]) entries_d[i] = ge[i-1] ? ins_entry : entries_q[i-1];
			end
		end else if (ctrl.pop) begin
			for (int i = 0; i < BOOK_DEPTH - 1; i++) entries_d[i] = entries_q[i+1];
		end else if (ctrl.set_qty) begin
			entries_d[0].qty = ctrl.new_qty;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < BOOK_DEPTH; i++) entries_q[i] <= entries_d[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.ins) begin
			count_q <= count_q + 1'b1;
		end else if (ctrl.pop) begin
			count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ rtl/ptom_back.sv @@
module ptom_back import ptom_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  queue_item_t      q_item,
	output logic             q_pop,
	output side_ctrl_t       bid_ctrl,
	output side_ctrl_t       ask_ctrl,
	input  book_entry_t      bid_head,
	input  book_entry_t      ask_head,
	input  logic [CNT_W-1:0] bid_count,
	input  logic [CNT_W-1:0] ask_count,
	ptom_result_if.source    result
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_MATCH = 2'b10
	} state_t;

	state_t            state_q, state_d;
	logic              obuf_free;
	logic              side_full;
	logic              crossed;
	logic [QTY_W-1:0]  tq;
	logic [QTY_W-1:0]  bid_left;
	logic [QTY_W-1:0]  ask_left;
	logic              load;
	kind_t             load_kind;
	logic              load_last;

	logic              res_valid_q;
	kind_t             kind_q;
	logic [ID_W-1:0]   buy_id_q;
	logic [ID_W-1:0]   sell_id_q;
	logic [PRICE_W-1:0] price_q;
	logic [QTY_W-1:0]  qty_q;
	logic              last_q;

	assign obuf_free = !res_valid_q || result.ready;
	assign side_full = q_item.side ? (ask_count == CNT_W'(BOOK_DEPTH))
		: (bid_count == CNT_W'(BOOK_DEPTH));
	assign crossed   = (bid_count != '0) && (ask_count != '0) &&
		(bid_head.price >= ask_head.price);
	assign tq        = (bid_head.qty < ask_head.qty) ? bid_head.qty : ask_head.qty;
	assign bid_left  = bid_head.qty - tq;
	assign ask_left  = ask_head.qty - tq;

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		load      = 1'b0;
		load_kind = KIND_SETTLED;
		load_last = 1'b1;
		bid_ctrl  = '0;
		ask_ctrl  = '0;
		bid_ctrl.new_qty = bid_left;
		ask_ctrl.new_qty = ask_left;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_item.invalid || side_full) begin
						if (obuf_free) begin
							q_pop     = 1'b1;
							load      = 1'b1;
							load_kind = q_item.invalid ? KIND_REJECTED : KIND_DROPPED;
						end
					end else begin
						q_pop        = 1'b1;
						bid_ctrl.ins = !q_item.side;
						ask_ctrl.ins = q_item.side;
						state_d      = ST_MATCH;
					end
				end
			end
			ST_MATCH: begin
				if (obuf_free) begin
					load = 1'b1;
					if (crossed) begin
						load_kind        = KIND_TRADE;
						load_last        = 1'b0;
						bid_ctrl.pop     = (bid_left == '0);
						bid_ctrl.set_qty = (bid_left != '0);
						ask_ctrl.pop     = (ask_left == '0);
						ask_ctrl.set_qty = (ask_left != '0);
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= load_kind;
			last_q <= load_last;
			if (load_kind == KIND_TRADE) begin
				buy_id_q  <= bid_head.id;
				sell_id_q <= ask_head.id;
				price_q   <= ask_head.price;
				qty_q     <= tq;
			end else begin
				buy_id_q  <= '0;
				sell_id_q <= '0;
				price_q   <= '0;
				qty_q     <= '0;
			end
		end
	end

	assign result.valid          = res_valid_q;
	assign result.kind           = kind_q;
	assign result.buy_order_id   = buy_id_q;
	assign result.sell_order_id  = sell_id_q;
	assign result.trade_price    = price_q;
	assign result.trade_quantity = qty_q;
	assign result.last           = last_q;

	// book never left crossed between orders
	a_uncrossed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && bid_count != '0 && ask_count != '0)
		|-> (bid_head.price < ask_head.price))
		else $error("book crossed while idle");

	a_ins_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(bid_ctrl.ins || ask_ctrl.ins) |-> (state_q == ST_IDLE && q_pop))
		else $error("insert outside idle");

	a_trade_qty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && kind_q == KIND_TRADE) |-> (qty_q != '0 && !last_q))
		else $error("bad trade beat");

	a_trade_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(load && load_kind == KIND_TRADE) |-> (bid_ctrl.pop || ask_ctrl.pop))
		else $error("trade consumed neither order");

endmodule

@@ rtl/price_time_order_matcher_core.sv @@
// Single-instrument limit order book with price-time priority, up to BOOK_DEPTH
// resting orders per side. Each order beat yields trade beats (at the ask
// price) followed by one status beat with last set; an order with price or
// quantity at or below zero, or arriving at a full side, gets one status beat
// only. A rejected or dropped order gets its status beat straight from idle; a
// resting order is first put into its side by a sorted insert, then its trades
// and status beat follow, all set by the single matching sequencer, which emits
// one result beat per cycle while the result output is not stalled. An input
// stage and a two-entry queue let orders keep arriving while results are
// stalled; both sides are kept sorted so the best order is always at the head.
module price_time_order_matcher_core import ptom_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	ptom_order_if.sink    order,
	ptom_result_if.source result
);

	logic             push;
	queue_item_t      push_item;
	logic             full;
	logic             q_pop;
	queue_item_t      q_item;
	logic             q_valid;
	side_ctrl_t       bid_ctrl;
	side_ctrl_t       ask_ctrl;
	book_entry_t      bid_head;
	book_entry_t      ask_head;
	logic [CNT_W-1:0] bid_count;
	logic [CNT_W-1:0] ask_count;

	ptom_front u_front (
		.clk(clk), .arst_n(arst_n), .order(order),
		.push(push), .push_item(push_item), .full(full)
	);

	ptom_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item), .full(full),
		.pop(q_pop), .item(q_item), .valid(q_valid)
	);

	ptom_side u_bids (
		.clk(clk), .arst_n(arst_n), .is_bid(1'b1), .ctrl(bid_ctrl),
		.ins_entry(q_item.entry), .head(bid_head), .count(bid_count)
	);

	ptom_side u_asks (
		.clk(clk), .arst_n(arst_n), .is_bid(1'b0), .ctrl(ask_ctrl),
		.ins_entry(q_item.entry), .head(ask_head), .count(ask_count)
	);

	ptom_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.bid_ctrl(bid_ctrl), .ask_ctrl(ask_ctrl), .bid_head(bid_head),
		.ask_head(ask_head), .bid_count(bid_count), .ask_count(ask_count),
		.result(result)
	);

endmodule
